// ===== design/lne_pkg.sv =====
// Shared types and constants for the DNS name label encoder.
package lne_pkg;

    // Default label buffer depth
    localparam int LABEL_MAX_DEF = 32;

    // Character and byte codes
    localparam logic [7:0] DOT_CHAR = 8'h2E;
    localparam logic [7:0] NAME_END = 8'h00;

    // Input op codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Input word: one name character or an end-of-name mark
    typedef struct packed {
        logic       op;
        logic [7:0] char_byte;
    } char_word_t;

    // Output word: one encoded byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       label_overflow;
    } enc_word_t;

    // Per-cycle control broadcast to the cell row
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== design/lne_cell.sv =====
// One byte cell of the label buffer row: loads at its own index, shifts toward the head.
module lne_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic             clk,
    input  lne_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0] wr_idx,
    input  logic [7:0]       char_byte,
    input  logic [7:0]       from_next,
    output logic [7:0]       data
);
    import lne_pkg::*;

    logic [7:0] data_reg;

    // Shift toward head while draining, else capture when addressed
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            data_reg <= from_next;
        end
        else if (ctl.load && (wr_idx == CNT_W'(IDX)))
        begin
            data_reg <= char_byte;
        end
    end

    assign data = data_reg;

endmodule

// ===== design/dns_name_label_encoder_core.sv =====
// DNS name label encoder: takes one character per word, after a dot or an end-of-name word it
// emits the length byte and the held label bytes, one per cycle, and after end-of-name a zero
// terminator. A plain character word never stalls the input. A dot word stalls it until the
// length byte and the n held characters (at most LABEL_MAX) have left, an end word until the
// terminator has left too; the label bytes leave a row of LABEL_MAX byte cells that shifts
// one position toward the head per output byte, so one byte leaves per cycle; output stall
// stretches this. Characters past LABEL_MAX are dropped and flagged on the terminator.
module dns_name_label_encoder_core #(
    parameter int LABEL_MAX = lne_pkg::LABEL_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  lne_pkg::char_word_t char_word,
    output logic                enc_valid,
    input  logic                enc_stall,
    output lne_pkg::enc_word_t  enc_word
);
    import lne_pkg::*;

    localparam int CNT_W = $clog2(LABEL_MAX + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_DATA = 2'd2;
    localparam logic [1:0] ST_TERM = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             is_end_reg, is_end_next;
    logic             enc_valid_reg, enc_valid_next;
    enc_word_t        enc_word_reg, enc_word_next;
    logic             emit;
    logic             slot_free;
    logic             accept;
    cell_ctl_t        ctl;
    logic [7:0]       cell_data [LABEL_MAX];

    assign slot_free  = !enc_valid_reg || !enc_stall;
    assign char_stall = (state_reg != ST_IDLE);
    assign accept     = char_valid && !char_stall;

    // Row of label cells; the head cell feeds the output
    for (genvar i = 0; i < LABEL_MAX; i++)
    begin : g_cell
        logic [7:0] nxt;
        if (i == LABEL_MAX - 1)
        begin : g_tail
            assign nxt = 8'h00;
        end
        else
        begin : g_mid
            assign nxt = cell_data[i+1];
        end
        lne_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .wr_idx    (count_reg),
            .char_byte (char_word.char_byte),
            .from_next (nxt),
            .data      (cell_data[i])
        );
    end

    // Sequencer: store characters, then drain length, label bytes, terminator
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        is_end_next    = is_end_reg;
        emit           = 1'b0;
        enc_word_next  = enc_word_reg;
        ctl.load       = 1'b0;
        ctl.shift      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (char_word.op == OP_END)
                    begin
                        is_end_next = 1'b1;
                        state_next  = ST_LEN;
                    end
                    else if (char_word.char_byte == DOT_CHAR)
                    begin
                        is_end_next = 1'b0;
                        state_next  = ST_LEN;
                    end
                    else if (count_reg < CNT_W'(LABEL_MAX))
                    begin
                        ctl.load   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_LEN:
            begin
                if (slot_free)
                begin
                    emit                         = 1'b1;
                    enc_word_next.out_byte       = 8'(count_reg);
                    enc_word_next.run_last       = !is_end_reg && (count_reg == '0);
                    enc_word_next.label_overflow = 1'b0;
                    if (count_reg != '0)
                    begin
                        state_next = ST_DATA;
                    end
                    else
                    begin
                        state_next = is_end_reg ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_DATA:
            begin
                if (slot_free)
                begin
                    emit                         = 1'b1;
                    ctl.shift                    = 1'b1;
                    enc_word_next.out_byte       = cell_data[0];
                    enc_word_next.run_last       = !is_end_reg && (count_reg == CNT_W'(1));
                    enc_word_next.label_overflow = 1'b0;
                    count_next                   = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = is_end_reg ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_TERM:
            begin
                if (slot_free)
                begin
                    emit                         = 1'b1;
                    enc_word_next.out_byte       = NAME_END;
                    enc_word_next.run_last       = 1'b1;
                    enc_word_next.label_overflow = ovf_reg;
                    ovf_next                     = 1'b0;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (emit)
        begin
            enc_valid_next = 1'b1;
        end
        else if (!enc_stall)
        begin
            enc_valid_next = 1'b0;
        end
        else
        begin
            enc_valid_next = enc_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            is_end_reg    <= 1'b0;
            enc_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            is_end_reg    <= is_end_next;
            enc_valid_reg <= enc_valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        enc_word_reg <= enc_word_next;
    end

    assign enc_valid = enc_valid_reg;
    assign enc_word  = enc_word_reg;

    // Held count never passes the buffer depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LABEL_MAX))
        else $error("label count beyond buffer depth");

    // Overflow flag only rides on a terminator byte
    a_ovf_on_term: assert property (@(posedge clk) disable iff (!rst_n)
        (enc_valid && enc_word.label_overflow) |->
            (enc_word.out_byte == NAME_END && enc_word.run_last))
        else $error("overflow flag on non-terminator byte");

    // Overflow is only raised with a full buffer
    a_ovf_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> ($past(count_reg) == CNT_W'(LABEL_MAX)))
        else $error("overflow set with room left");

    // Dot or end word starts a drain with the length byte
    a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (char_word.op == OP_END || char_word.char_byte == DOT_CHAR))
            |=> (state_reg == ST_LEN))
        else $error("drain did not start");

    // The row shifts only when a label byte leaves
    a_shift_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |=> (enc_valid && enc_word.label_overflow == 1'b0))
        else $error("shift without output byte");

endmodule
